@@ design/dotq_pkg.sv @@
// shared types and constants of the deadline ordered task queue
// no dependencies; every design file refers to it by scoped names
`default_nettype none

package dotq_pkg;

   localparam int SLOT_LIMIT_DEFAULT = 32;
   localparam int DEADLINE_W         = 64;
   localparam int SLOT_NUM_W         = 5;
   localparam int OP_W               = 2;
   localparam int STATUS_W           = 2;
   localparam int ACTIVE_W           = 5;
   localparam int CSR_ADDR_W         = 3;
   localparam int CSR_DATA_W         = 32;

   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd31;
   localparam logic [0:0]          REG_ACTIVE_SLOTS = 1'b0;

   typedef enum logic [OP_W-1:0] {
      OP_REGISTER   = 2'd0,
      OP_RESCHEDULE = 2'd1,
      OP_SERVICE    = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_BAD_SLOT = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_CHECK,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic scan;
      logic fetch;
      logic write;
      logic drop;
   } ram_cmd_type;

   typedef struct packed {
      logic valid;
      logic le;
      logic head;
   } ram_step_type;

   typedef struct packed {
      logic [SLOT_NUM_W-1:0] chosen_slot;
      logic                  slot_due;
      logic [DEADLINE_W-1:0] earliest_deadline;
      status_type            status;
   } result_type;

endpackage

`default_nettype wire

@@ design/dotq_slot_ram.sv @@
// slot deadline and queue rank memories with the read-modify-write rank update
// depends on dotq_pkg
`default_nettype none

module dotq_slot_ram #(
   parameter int SLOT_LIMIT = dotq_pkg::SLOT_LIMIT_DEFAULT
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  dotq_pkg::ram_cmd_type                cmd,
   input  wire  [$clog2(SLOT_LIMIT)-1:0]        rd_addr,
   input  wire  [$clog2(SLOT_LIMIT)-1:0]        wr_addr,
   input  wire  [$clog2(SLOT_LIMIT)-1:0]        wr_rank,
   input  wire  [$clog2(SLOT_LIMIT)-1:0]        ref_rank,
   input  wire  [dotq_pkg::DEADLINE_W-1:0]      new_deadline,
   output logic [dotq_pkg::DEADLINE_W-1:0]      rd_deadline,
   output logic [$clog2(SLOT_LIMIT)-1:0]        rd_rank,
   output dotq_pkg::ram_step_type               step,
   output logic [$clog2(SLOT_LIMIT)-1:0]        step_addr
);

   localparam int NSLOT = SLOT_LIMIT - 1;
   localparam int SW    = $clog2(SLOT_LIMIT);

   logic [dotq_pkg::DEADLINE_W-1:0] dl_mem [NSLOT];
   logic [SW-1:0]                   rk_mem [NSLOT];

   logic [dotq_pkg::DEADLINE_W-1:0] dl_rd_ff;
   logic [SW-1:0]                   rk_rd_ff;
   logic                            pend_ff;
   logic                            pend_in;
   logic [SW-1:0]                   pend_addr_ff;

   logic          le;
   logic          dec;
   logic [SW-1:0] rank_new;

   assign pend_in = cmd.scan;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan || cmd.fetch) begin
         dl_rd_ff <= dl_mem[rd_addr];
         rk_rd_ff <= rk_mem[rd_addr];
      end
      pend_addr_ff <= rd_addr;
   end

   // rank after taking the moving slot out and putting it back at its new deadline
   always_comb begin
      le       = dl_rd_ff <= new_deadline;
      dec      = cmd.drop && (rk_rd_ff > ref_rank);
      rank_new = rk_rd_ff - SW'(dec) + SW'(!le);
   end

   always_ff @(posedge clock) begin
      if (pend_ff) begin
         rk_mem[pend_addr_ff] <= rank_new;
      end else if (cmd.write) begin
         rk_mem[wr_addr] <= wr_rank;
      end
      if (cmd.write) begin
         dl_mem[wr_addr] <= new_deadline;
      end
   end

   assign rd_deadline = dl_rd_ff;
   assign rd_rank     = rk_rd_ff;
   assign step_addr   = pend_addr_ff;
   assign step.valid  = pend_ff;
   assign step.le     = le;
   assign step.head   = rank_new == '0;

endmodule

`default_nettype wire

@@ design/dotq_ctrl.sv @@
// command sequencer: allocation, slot scan, head tracking and result build
// depends on dotq_pkg; drives dotq_slot_ram
`default_nettype none

module dotq_ctrl #(
   parameter int SLOT_LIMIT = dotq_pkg::SLOT_LIMIT_DEFAULT
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire  [dotq_pkg::ACTIVE_W-1:0]        active_slots,
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  wire  [dotq_pkg::OP_W-1:0]            req_operation,
   input  wire  [dotq_pkg::SLOT_NUM_W-1:0]      req_slot_number,
   input  wire  [dotq_pkg::DEADLINE_W-1:0]      req_new_deadline,
   input  wire  [dotq_pkg::DEADLINE_W-1:0]      req_current_time,
   input  wire                                  out_free,
   output logic                                 res_valid,
   output dotq_pkg::result_type                 res,
   output dotq_pkg::ram_cmd_type                cmd,
   output logic [$clog2(SLOT_LIMIT)-1:0]        rd_addr,
   output logic [$clog2(SLOT_LIMIT)-1:0]        wr_addr,
   output logic [$clog2(SLOT_LIMIT)-1:0]        wr_rank,
   output logic [$clog2(SLOT_LIMIT)-1:0]        ref_rank,
   output logic [dotq_pkg::DEADLINE_W-1:0]      new_deadline,
   input  wire  [dotq_pkg::DEADLINE_W-1:0]      rd_deadline,
   input  wire  [$clog2(SLOT_LIMIT)-1:0]        rd_rank,
   input  dotq_pkg::ram_step_type               step,
   input  wire  [$clog2(SLOT_LIMIT)-1:0]        step_addr
);

   localparam int NSLOT = SLOT_LIMIT - 1;
   localparam int SW    = $clog2(SLOT_LIMIT);
   localparam int CAP   = 1 << SW;
   localparam int DW    = dotq_pkg::DEADLINE_W;
   localparam int NW    = dotq_pkg::SLOT_NUM_W;

   dotq_pkg::state_type  state_ff, state_in;
   dotq_pkg::op_type     op_ff, op_in;
   dotq_pkg::status_type status_ff, status_in;
   logic [NW-1:0]        num_ff, num_in;
   logic [DW-1:0]        dl_ff, dl_in;
   logic [DW-1:0]        now_ff, now_in;
   logic [SW-1:0]        slot_ff, slot_in;
   logic [SW-1:0]        cnt_ff, cnt_in;
   logic [SW-1:0]        pos_ff, pos_in;
   logic [SW-1:0]        ref_ff, ref_in;
   logic                 drop_ff, drop_in;
   logic [CAP-1:0]       use_ff, use_in;
   logic [SW-1:0]        hd_slot_ff, hd_slot_in;
   logic [DW-1:0]        hd_dl_ff, hd_dl_in;
   logic [SW-1:0]        nh_slot_ff, nh_slot_in;
   logic [DW-1:0]        nh_dl_ff, nh_dl_in;
   logic [NW-1:0]        chosen_ff, chosen_in;
   logic                 due_ff, due_in;

   logic [dotq_pkg::ACTIVE_W-1:0] act;
   logic                          found;
   logic [SW-1:0]                 alloc;
   logic [NW-1:0]                 num_m1;
   logic [SW-1:0]                 num_idx;
   logic                          bad;
   logic                          head_due;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dotq_pkg::ST_IDLE;
         use_ff   <= '0;
      end else begin
         state_ff <= state_in;
         use_ff   <= use_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      status_ff  <= status_in;
      num_ff     <= num_in;
      dl_ff      <= dl_in;
      now_ff     <= now_in;
      slot_ff    <= slot_in;
      cnt_ff     <= cnt_in;
      pos_ff     <= pos_in;
      ref_ff     <= ref_in;
      drop_ff    <= drop_in;
      hd_slot_ff <= hd_slot_in;
      hd_dl_ff   <= hd_dl_in;
      nh_slot_ff <= nh_slot_in;
      nh_dl_ff   <= nh_dl_in;
      chosen_ff  <= chosen_in;
      due_ff     <= due_in;
   end

   // effective active count, lowest free slot, reschedule check, due test
   always_comb begin
      if ({1'b0, active_slots} > 6'(NSLOT)) begin
         act = dotq_pkg::ACTIVE_W'(NSLOT);
      end else begin
         act = active_slots;
      end
      found = 1'b0;
      alloc = '0;
      for (int i = CAP - 1; i >= 0; i--) begin
         if (!use_ff[i] && (i < int'(act))) begin
            found = 1'b1;
            alloc = SW'(i);
         end
      end
      num_m1   = num_ff - 5'd1;
      num_idx  = SW'(num_m1);
      bad      = (num_ff == '0) || (num_ff > act) || !use_ff[num_idx];
      head_due = (|use_ff) && (hd_dl_ff != '1) && (hd_dl_ff <= now_ff);
   end

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      status_in  = status_ff;
      num_in     = num_ff;
      dl_in      = dl_ff;
      now_in     = now_ff;
      slot_in    = slot_ff;
      cnt_in     = cnt_ff;
      pos_in     = pos_ff;
      ref_in     = ref_ff;
      drop_in    = drop_ff;
      use_in     = use_ff;
      hd_slot_in = hd_slot_ff;
      hd_dl_in   = hd_dl_ff;
      nh_slot_in = nh_slot_ff;
      nh_dl_in   = nh_dl_ff;
      chosen_in  = chosen_ff;
      due_in     = due_ff;
      cmd        = '0;
      cmd.drop   = drop_ff;
      rd_addr    = cnt_ff;
      req_ready  = 1'b0;
      res_valid  = 1'b0;

      // updated rank coming back from the memory
      if (step.valid) begin
         if (step.le) begin
            pos_in = pos_ff + SW'(1);
         end
         if (step.head) begin
            nh_slot_in = step_addr;
            nh_dl_in   = rd_deadline;
         end
      end

      case (state_ff)
         dotq_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in    = dotq_pkg::op_type'(req_operation);
               num_in   = req_slot_number;
               dl_in    = req_new_deadline;
               now_in   = req_current_time;
               state_in = dotq_pkg::ST_DECIDE;
            end
         end
         dotq_pkg::ST_DECIDE: begin
            chosen_in = '0;
            due_in    = 1'b0;
            status_in = dotq_pkg::STATUS_OK;
            state_in  = dotq_pkg::ST_DONE;
            case (op_ff)
               dotq_pkg::OP_REGISTER: begin
                  if (found) begin
                     slot_in  = alloc;
                     drop_in  = 1'b0;
                     pos_in   = '0;
                     cnt_in   = '0;
                     state_in = dotq_pkg::ST_SCAN;
                  end else begin
                     status_in = dotq_pkg::STATUS_FULL;
                  end
               end
               dotq_pkg::OP_RESCHEDULE: begin
                  if (bad) begin
                     status_in = dotq_pkg::STATUS_BAD_SLOT;
                  end else begin
                     slot_in   = num_idx;
                     rd_addr   = num_idx;
                     cmd.fetch = 1'b1;
                     state_in  = dotq_pkg::ST_CHECK;
                  end
               end
               dotq_pkg::OP_SERVICE: begin
                  if (head_due) begin
                     chosen_in = NW'(hd_slot_ff) + 5'd1;
                     due_in    = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
         dotq_pkg::ST_CHECK: begin
            if (rd_deadline == dl_ff) begin
               state_in = dotq_pkg::ST_DONE;
            end else begin
               ref_in   = rd_rank;
               drop_in  = 1'b1;
               pos_in   = '0;
               cnt_in   = '0;
               state_in = dotq_pkg::ST_SCAN;
            end
         end
         dotq_pkg::ST_SCAN: begin
            cmd.scan = use_ff[cnt_ff] && (cnt_ff != slot_ff);
            cnt_in   = cnt_ff + SW'(1);
            if (cnt_ff == SW'(NSLOT - 1)) begin
               state_in = dotq_pkg::ST_DRAIN;
            end
         end
         dotq_pkg::ST_DRAIN: begin
            state_in = dotq_pkg::ST_FINISH;
         end
         dotq_pkg::ST_FINISH: begin
            cmd.write        = 1'b1;
            use_in[slot_ff]  = 1'b1;
            if (pos_ff == '0) begin
               hd_slot_in = slot_ff;
               hd_dl_in   = dl_ff;
            end else begin
               hd_slot_in = nh_slot_ff;
               hd_dl_in   = nh_dl_ff;
            end
            if (op_ff == dotq_pkg::OP_REGISTER) begin
               chosen_in = NW'(slot_ff) + 5'd1;
            end
            state_in = dotq_pkg::ST_DONE;
         end
         dotq_pkg::ST_DONE: begin
            res_valid = out_free;
            if (out_free) begin
               state_in = dotq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dotq_pkg::ST_IDLE;
         end
      endcase
   end

   assign wr_addr      = slot_ff;
   assign wr_rank      = pos_ff;
   assign ref_rank     = ref_ff;
   assign new_deadline = dl_ff;

   assign res.chosen_slot       = chosen_ff;
   assign res.slot_due          = due_ff;
   assign res.earliest_deadline = (|use_ff) ? hd_dl_ff : '1;
   assign res.status            = status_ff;

endmodule

`default_nettype wire

@@ design/deadline_ordered_task_queue.sv @@
// top level of the deadline ordered task queue: csr port, result register, checks
// depends on dotq_pkg, dotq_slot_ram and dotq_ctrl
//
//   channel  ports   direction  handshake            beat
//   req      req_*   in         req_valid/req_ready  one command
//   rsp      rsp_*   out        rsp_valid/rsp_ready  one result
//   csr      csr_*   in/out     apb setup + access   one register write or read
//
// register and reschedule walk every slot once through the rank memory; reschedule
// first fetches the slot and skips the walk if its deadline is unchanged
// service and rejected commands skip the walk; the next beat is taken after the result leaves
// the result register frees the sequencer, so a stalled rsp side holds at most one result
// synchronous reset clears the in-use flags and control; no memory clearing pass is needed
`default_nettype none

module deadline_ordered_task_queue #(
   parameter int SLOT_LIMIT = dotq_pkg::SLOT_LIMIT_DEFAULT
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_ready,
   input  wire  [dotq_pkg::OP_W-1:0]             req_operation,
   input  wire  [dotq_pkg::SLOT_NUM_W-1:0]       req_slot_number,
   input  wire  [dotq_pkg::DEADLINE_W-1:0]       req_new_deadline,
   input  wire  [dotq_pkg::DEADLINE_W-1:0]       req_current_time,
   output logic                                  rsp_valid,
   input  wire                                   rsp_ready,
   output logic [dotq_pkg::SLOT_NUM_W-1:0]       rsp_chosen_slot,
   output logic                                  rsp_slot_due,
   output logic [dotq_pkg::DEADLINE_W-1:0]       rsp_earliest_deadline,
   output logic [dotq_pkg::STATUS_W-1:0]         rsp_status,
   input  wire                                   csr_psel,
   input  wire                                   csr_penable,
   input  wire                                   csr_pwrite,
   input  wire  [dotq_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  wire  [dotq_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [dotq_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);

   localparam int SW = $clog2(SLOT_LIMIT);

   logic [dotq_pkg::ACTIVE_W-1:0] active_ff, active_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   dotq_pkg::result_type          rsp_data_ff, rsp_data_in;

   logic                          out_free;
   logic                          res_valid;
   dotq_pkg::result_type          res;
   dotq_pkg::ram_cmd_type         cmd;
   dotq_pkg::ram_step_type        step;
   logic [SW-1:0]                 rd_addr;
   logic [SW-1:0]                 wr_addr;
   logic [SW-1:0]                 wr_rank;
   logic [SW-1:0]                 ref_rank;
   logic [SW-1:0]                 rd_rank;
   logic [SW-1:0]                 step_addr;
   logic [dotq_pkg::DEADLINE_W-1:0] new_deadline;
   logic [dotq_pkg::DEADLINE_W-1:0] rd_deadline;
   logic                          csr_hit;

   // csr
   assign csr_pready = 1'b1;
   assign csr_hit    = csr_paddr[dotq_pkg::CSR_ADDR_W-1:2] == dotq_pkg::REG_ACTIVE_SLOTS;

   always_comb begin
      active_in = active_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         active_in = csr_pwdata[dotq_pkg::ACTIVE_W-1:0];
      end
      if (csr_hit) begin
         csr_prdata = dotq_pkg::CSR_DATA_W'(active_ff);
      end else begin
         csr_prdata = '0;
      end
   end

   // result register
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= dotq_pkg::ACTIVE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_chosen_slot       = rsp_data_ff.chosen_slot;
   assign rsp_slot_due          = rsp_data_ff.slot_due;
   assign rsp_earliest_deadline = rsp_data_ff.earliest_deadline;
   assign rsp_status            = rsp_data_ff.status;

   dotq_ctrl #(
      .SLOT_LIMIT (SLOT_LIMIT)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .active_slots     (active_ff),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_slot_number  (req_slot_number),
      .req_new_deadline (req_new_deadline),
      .req_current_time (req_current_time),
      .out_free         (out_free),
      .res_valid        (res_valid),
      .res              (res),
      .cmd              (cmd),
      .rd_addr          (rd_addr),
      .wr_addr          (wr_addr),
      .wr_rank          (wr_rank),
      .ref_rank         (ref_rank),
      .new_deadline     (new_deadline),
      .rd_deadline      (rd_deadline),
      .rd_rank          (rd_rank),
      .step             (step),
      .step_addr        (step_addr)
   );

   dotq_slot_ram #(
      .SLOT_LIMIT (SLOT_LIMIT)
   ) u_slot_ram (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .rd_addr      (rd_addr),
      .wr_addr      (wr_addr),
      .wr_rank      (wr_rank),
      .ref_rank     (ref_rank),
      .new_deadline (new_deadline),
      .rd_deadline  (rd_deadline),
      .rd_rank      (rd_rank),
      .step         (step),
      .step_addr    (step_addr)
   );

   // one command in flight at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("command taken while another is in flight");

   // a stalled result is never overwritten
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !res_valid)
      else $error("result register overwritten while stalled");

   // a due slot is reported with a real slot number and a real deadline
   a_due_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_slot_due |-> (rsp_chosen_slot != '0) && (rsp_earliest_deadline != '1))
      else $error("due result without slot or deadline");

   // a full queue never reports an allocated slot
   a_full_no_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == dotq_pkg::STATUS_FULL) |-> (rsp_chosen_slot == '0))
      else $error("full status with a slot number");

endmodule

`default_nettype wire
